// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/tme_pkg.sv -----
package tme_pkg;

  localparam int TAPE_DEPTH = 32768;
  localparam int ADDR_W = $clog2(TAPE_DEPTH);

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t CP_RESET = addr_t'(TAPE_DEPTH / 2);
  localparam addr_t ADDR_LAST = addr_t'(TAPE_DEPTH - 1);

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_LEFT    = 4'd2,
    OP_PTR_INC = 4'd3,
    OP_SCAN    = 4'd4,
    OP_EMIT    = 4'd5,
    OP_JZ      = 4'd6,
    OP_JNZ     = 4'd7,
    OP_BREAK   = 4'd8,
    OP_END     = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,
    STOP_BREAK   = 2'd1,
    STOP_END     = 2'd2,
    STOP_INVALID = 2'd3
  } stop_t;

endpackage

// ----- rtl/tme_if.sv -----
interface tme_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [15:0] jump_target;
  logic [7:0]  in_byte;

  modport source (output valid, output operation, output jump_target, output in_byte,
                  input ready);
  modport sink (input valid, input operation, input jump_target, input in_byte,
                output ready);
endinterface

interface tme_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_ip;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic [1:0]  stop_code;

  modport source (output valid, output next_ip, output out_byte, output out_valid,
                  output stop_code, input ready);
  modport sink (input valid, input next_ip, input out_byte, input out_valid,
                input stop_code, output ready);
endinterface

interface tme_cfg_if;
  logic valid;
  logic ready;
  logic single_step;

  modport source (output valid, output single_step, input ready);
  modport sink (input valid, input single_step, output ready);
endinterface

// ----- rtl/tme_ram.sv -----
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tape_machine_executor.sv -----
// Each item is registered into the execute stage when accepted, and its
// result is loaded into the result register when it leaves that stage.
// Throughput: one item per cycle while results are taken; the tape memory
// is read when an item is accepted and written back when it leaves the
// execute stage, with forwarding between. Reset (rst, synchronous): tape
// cleared one cell a cycle, cmd.ready low meanwhile; cell pointer to
// mid-tape, instruction pointer and single_step to zero.
`include "assert_macros.svh"

module tape_machine_executor (
  input  logic             clk,
  input  logic             rst,
  tme_in_if.sink           cmd,
  tme_out_if.source        res,
  tme_cfg_if.sink          cfg
);

  tme_pkg::addr_t cell_pointer;
  tme_pkg::addr_t cell_pointer_next;
  logic [15:0]    instr_pointer;
  logic           single_step;

  tme_pkg::addr_t clr_addr;
  logic           clr_done;

  logic           s1_valid;
  tme_pkg::op_t   s1_op;
  logic [15:0]    s1_target;
  logic [7:0]     s1_byte;
  tme_pkg::addr_t s1_addr;
  logic           s1_fwd;
  logic [7:0]     s1_fwd_data;

  logic           res_full;
  logic           s1_go;
  logic           accept;
  logic           fwd_hit;

  logic [7:0]     rd_data;
  logic [7:0]     cur_byte;
  logic [7:0]     cell_new;
  logic           cell_wr;
  logic [15:0]    ip_new;
  logic [7:0]     obyte;
  logic           ovalid;
  tme_pkg::stop_t stop;
  logic           ordinary;

  logic           ram_we;
  tme_pkg::addr_t ram_waddr;
  logic [7:0]     ram_wdata;
  logic           wb_en;
  tme_pkg::op_t   cmd_op;

  assign cmd_op = tme_pkg::op_t'(cmd.operation);
  assign s1_go  = s1_valid && (!res_full || res.ready);
  assign cmd.ready = clr_done && (!s1_valid || s1_go);
  assign accept = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // execute stage
  assign cur_byte = s1_fwd ? s1_fwd_data : rd_data;

  always_comb begin
    cell_new = cur_byte;
    cell_wr  = 1'b0;
    ip_new   = instr_pointer;
    obyte    = 8'd0;
    ovalid   = 1'b0;
    stop     = tme_pkg::STOP_NONE;
    ordinary = 1'b1;
    unique case (s1_op)
      tme_pkg::OP_ADD: begin
        cell_new = cur_byte + 8'd1;
        cell_wr  = 1'b1;
        ip_new   = instr_pointer + 16'd1;
      end
      tme_pkg::OP_SUB: begin
        cell_new = cur_byte - 8'd1;
        cell_wr  = 1'b1;
        ip_new   = instr_pointer + 16'd1;
      end
      tme_pkg::OP_LEFT, tme_pkg::OP_PTR_INC: begin
        ip_new = instr_pointer + 16'd1;
      end
      tme_pkg::OP_SCAN: begin
        cell_new = s1_byte;
        cell_wr  = 1'b1;
        ip_new   = instr_pointer + 16'd1;
      end
      tme_pkg::OP_EMIT: begin
        obyte  = cur_byte;
        ovalid = 1'b1;
        ip_new = instr_pointer + 16'd1;
      end
      tme_pkg::OP_JZ: begin
        ip_new = (cur_byte == 8'd0) ? s1_target : instr_pointer + 16'd3;
      end
      tme_pkg::OP_JNZ: begin
        ip_new = (cur_byte != 8'd0) ? s1_target : instr_pointer + 16'd3;
      end
      tme_pkg::OP_BREAK: begin
        stop = tme_pkg::STOP_BREAK;
      end
      tme_pkg::OP_END: begin
        stop     = tme_pkg::STOP_END;
        ordinary = 1'b0;
      end
      default: begin
        stop     = tme_pkg::STOP_INVALID;
        ordinary = 1'b0;
      end
    endcase
    if (ordinary && single_step) begin
      stop = tme_pkg::STOP_BREAK;
    end
  end

  assign wb_en   = s1_go && cell_wr;
  assign fwd_hit = wb_en && (s1_addr == cell_pointer);

  always_comb begin
    cell_pointer_next = cell_pointer;
    case (cmd_op)
      tme_pkg::OP_LEFT: begin
        cell_pointer_next = (cell_pointer == '0) ? tme_pkg::ADDR_LAST
                                                 : cell_pointer - tme_pkg::addr_t'(1);
      end
      tme_pkg::OP_PTR_INC: begin
        cell_pointer_next = (cell_pointer == tme_pkg::ADDR_LAST) ? '0
                            : cell_pointer + tme_pkg::addr_t'(1);
      end
      default: begin
        cell_pointer_next = cell_pointer;
      end
    endcase
  end

  // clear pass owns the write port until done
  assign ram_we    = !clr_done || wb_en;
  assign ram_waddr = clr_done ? s1_addr : clr_addr;
  assign ram_wdata = clr_done ? cell_new : 8'd0;

  tme_ram #(
    .WIDTH (8),
    .DEPTH (tme_pkg::TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (cell_pointer),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      clr_addr <= clr_addr + tme_pkg::addr_t'(1);
      clr_done <= (clr_addr == tme_pkg::ADDR_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      single_step <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      single_step <= cfg.single_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_pointer  <= tme_pkg::CP_RESET;
      instr_pointer <= '0;
      s1_valid      <= 1'b0;
      res_full      <= 1'b0;
    end else begin
      if (accept) begin
        cell_pointer <= cell_pointer_next;
      end
      if (s1_go) begin
        instr_pointer <= ip_new;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        res_full <= 1'b1;
      end else if (res.ready) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= cmd_op;
      s1_target   <= cmd.jump_target;
      s1_byte     <= cmd.in_byte;
      s1_addr     <= cell_pointer;
      s1_fwd      <= fwd_hit;
      s1_fwd_data <= cell_new;
    end
    if (s1_go) begin
      res.next_ip   <= ip_new;
      res.out_byte  <= obyte;
      res.out_valid <= ovalid;
      res.stop_code <= stop;
    end
  end

  assign res.valid = res_full;

  `ASSERT_NOW(a_no_item_in_clear, clk, rst, cmd.valid && cmd.ready, clr_done)
  `ASSERT_NEXT(a_exec_fills_out, clk, rst, s1_go, res_full)
  `ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !s1_go, s1_valid && $stable(s1_addr))
  `ASSERT_NEXT(a_stop_keeps_ip, clk, rst,
               s1_go && (s1_op == tme_pkg::OP_BREAK || s1_op == tme_pkg::OP_END),
               $stable(instr_pointer))

endmodule

// ----- dv/testbench.sv -----
module testbench;

  localparam logic [3:0] OP_INVALID_FIRST = 4'd10;
  localparam logic [3:0] OP_INVALID_LAST  = 4'd15;
  localparam int RESET_CYCLES    = 12;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_LIMIT     = 5000;

  typedef struct packed {
    logic [15:0] next_ip;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [1:0]  stop_code;
  } exec_result_t;

  class tape_scoreboard;
    logic [7:0]     tape [tme_pkg::TAPE_DEPTH];
    tme_pkg::addr_t cell_ptr;
    logic [15:0]    instr_ptr;
    logic           single_step;
    exec_result_t   pending_results[$];
    int             items_seen;
    int             results_seen;
    int             prints_seen;
    int             stops_seen [4];
    int             failures;

    function new();
      foreach (tape[i]) tape[i] = 8'd0;
      cell_ptr = tme_pkg::CP_RESET;
      instr_ptr = 16'd0;
      single_step = 1'b0;
      items_seen = 0;
      results_seen = 0;
      prints_seen = 0;
      foreach (stops_seen[i]) stops_seen[i] = 0;
      failures = 0;
    endfunction

    function void note_instr(logic [3:0] op, logic [15:0] target, logic [7:0] data);
      exec_result_t r;
      logic [7:0]   cur_byte;
      logic         plain;
      cur_byte = tape[cell_ptr];
      r = '0;
      plain = 1'b1;
      case (op)
        tme_pkg::OP_ADD: begin
          tape[cell_ptr] = cur_byte + 8'd1;
          instr_ptr = instr_ptr + 16'd1;
        end
        tme_pkg::OP_SUB: begin
          tape[cell_ptr] = cur_byte - 8'd1;
          instr_ptr = instr_ptr + 16'd1;
        end
        tme_pkg::OP_LEFT: begin
          cell_ptr = (cell_ptr == '0) ? tme_pkg::ADDR_LAST
                                      : cell_ptr - tme_pkg::addr_t'(1);
          instr_ptr = instr_ptr + 16'd1;
        end
        tme_pkg::OP_PTR_INC: begin
          cell_ptr = (cell_ptr == tme_pkg::ADDR_LAST) ? '0
                                                      : cell_ptr + tme_pkg::addr_t'(1);
          instr_ptr = instr_ptr + 16'd1;
        end
        tme_pkg::OP_SCAN: begin
          tape[cell_ptr] = data;
          instr_ptr = instr_ptr + 16'd1;
        end
        tme_pkg::OP_EMIT: begin
          r.out_byte = cur_byte;
          r.out_valid = 1'b1;
          instr_ptr = instr_ptr + 16'd1;
        end
        tme_pkg::OP_JZ: begin
          instr_ptr = (cur_byte == 8'd0) ? target : instr_ptr + 16'd3;
        end
        tme_pkg::OP_JNZ: begin
          instr_ptr = (cur_byte != 8'd0) ? target : instr_ptr + 16'd3;
        end
        tme_pkg::OP_BREAK: begin
          r.stop_code = tme_pkg::STOP_BREAK;
        end
        tme_pkg::OP_END: begin
          r.stop_code = tme_pkg::STOP_END;
          plain = 1'b0;
        end
        default: begin
          r.stop_code = tme_pkg::STOP_INVALID;
          plain = 1'b0;
        end
      endcase
      if (plain && single_step) r.stop_code = tme_pkg::STOP_BREAK;
      r.next_ip = instr_ptr;
      pending_results.push_back(r);
      items_seen++;
    endfunction

    function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
        failures++;
      end
    endfunction

    function void check_result(logic [15:0] next_ip, logic [7:0] out_byte, logic out_valid,
                               logic [1:0] stop_code);
      exec_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ip %h byte %h valid %b stop %0d",
                 $time, next_ip, out_byte, out_valid, stop_code);
        failures++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("next_ip", e.next_ip, next_ip);
      compare_field("out_byte", 16'(e.out_byte), 16'(out_byte));
      compare_field("out_valid", 16'(e.out_valid), 16'(out_valid));
      compare_field("stop_code", 16'(e.stop_code), 16'(stop_code));
      results_seen++;
      if (e.out_valid) prints_seen++;
      stops_seen[e.stop_code]++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic sender_idles;
  logic sink_hold_req;
  tape_scoreboard sb;

  tme_in_if  cmd_if ();
  tme_out_if res_if ();
  tme_cfg_if cfg_if ();

  tape_machine_executor dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && cmd_if.valid && cmd_if.ready)
      sb.note_instr(cmd_if.operation, cmd_if.jump_target, cmd_if.in_byte);
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.next_ip, res_if.out_byte, res_if.out_valid, res_if.stop_code);
    if (!rst && cfg_if.valid && cfg_if.ready)
      sb.single_step = cfg_if.single_step;
  end

  initial begin : result_sink
    int gap;
    int run;
    res_if.ready <= 1'b0;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        gap = SINK_HOLD_CYCLES;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      end
      repeat (gap) begin
        @(posedge clk);
        res_if.ready <= 1'b0;
      end
      run = $urandom_range(1, 12);
      repeat (run) begin
        @(posedge clk);
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [3:0] op, input logic [15:0] target,
                           input logic [7:0] data);
    int gap;
    gap = sender_idles ? pick_gap() : 0;
    repeat (gap) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.jump_target <= target;
    cmd_if.in_byte <= data;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
  endtask

  task automatic send_random_item();
    logic [3:0]  op;
    logic [15:0] target;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 92) op = 4'($urandom_range(tme_pkg::OP_ADD, tme_pkg::OP_END));
    else op = 4'($urandom_range(OP_INVALID_FIRST, OP_INVALID_LAST));
    r = $urandom_range(0, 19);
    if (r == 0) target = 16'h0000;
    else if (r == 1) target = 16'hFFFF;
    else target = 16'($urandom_range(0, 65535));
    send_item(op, target, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_run(input int count, input bit gapless);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) sender_idles = !gapless && ($urandom_range(0, 3) != 0);
      send_random_item();
    end
  endtask

  // hold valid low until every expected result has come back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_single_step(input logic value);
    cfg_if.valid <= 1'b1;
    cfg_if.single_step <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    sb = new();
    sender_idles = 1'b1;
    sink_hold_req = 1'b0;
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.operation <= tme_pkg::OP_ADD;
    cmd_if.jump_target <= 16'h0000;
    cmd_if.in_byte <= 8'h00;
    cfg_if.valid <= 1'b0;
    cfg_if.single_step <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    write_single_step(1'b0);

    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_JNZ, 16'hFFFF, 8'h00);
    send_item(tme_pkg::OP_JZ, 16'hFFFF, 8'hFF);
    send_item(tme_pkg::OP_ADD, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_SUB, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_SUB, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_JNZ, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_JZ, 16'hABCD, 8'h00);
    send_item(tme_pkg::OP_SCAN, 16'h0000, 8'hFF);
    send_item(tme_pkg::OP_ADD, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_JZ, 16'hFFFE, 8'h00);
    send_item(tme_pkg::OP_JNZ, 16'h5555, 8'h00);
    send_item(tme_pkg::OP_PTR_INC, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_SCAN, 16'h0000, 8'h5A);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_LEFT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_BREAK, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_END, 16'h0000, 8'h00);
    for (int c = OP_INVALID_FIRST; c <= OP_INVALID_LAST; c++)
      send_item(4'(c), 16'hFFFF, 8'hFF);

    send_item(tme_pkg::OP_ADD, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_LEFT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_SCAN, 16'h0000, 8'h80);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_PTR_INC, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_LEFT, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_EMIT, 16'h0000, 8'h00);

    drain_results();
    write_single_step(1'b1);
    send_item(tme_pkg::OP_BREAK, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_END, 16'h0000, 8'h00);
    send_item(OP_INVALID_FIRST, 16'h0000, 8'h00);
    send_item(tme_pkg::OP_ADD, 16'h0000, 8'h00);
    random_run(500, 1'b0);

    drain_results();
    write_single_step(1'b0);
    sink_hold_req = 1'b1;
    random_run(200, 1'b1);
    drain_results();
    random_run(300, 1'b0);

    drain_results();
    write_single_step(1'b1);
    random_run(410, 1'b0);

    cmd_if.valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && sb.pending_results.size() != 0; w++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected next ip %h", $time,
               sb.pending_results.size(), sb.pending_results[0].next_ip);
      sb.failures++;
    end
    $display("ran %0d instructions, %0d results checked, %0d prints, both step modes",
             sb.items_seen, sb.results_seen, sb.prints_seen);
    $display("stops seen: break %0d, end %0d, invalid %0d",
             sb.stops_seen[tme_pkg::STOP_BREAK], sb.stops_seen[tme_pkg::STOP_END],
             sb.stops_seen[tme_pkg::STOP_INVALID]);
    if (sb.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// ----- tape_machine_executor.f -----
+incdir+rtl
rtl/tme_pkg.sv
rtl/tme_if.sv
rtl/tme_ram.sv
rtl/tape_machine_executor.sv
dv/testbench.sv
